// ----- hdl/hashed_timer_wheel_assert.svh -----
// Assertion macros for the hashed timer wheel.
`ifndef HASHED_TIMER_WHEEL_ASSERT_SVH
`define HASHED_TIMER_WHEEL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HTW_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTW_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/htw_pkg.sv -----
// Types and constants of the hashed timer wheel.
package htw_pkg;

  // WHEEL_SLOTS is a power of two: a delay splits into rounds and slot by bit fields
  localparam int WHEEL_SLOTS  = 32;
  localparam int NUM_ENTRIES  = 16;
  localparam int RESULT_LIMIT = 16;

  localparam int OP_W    = 2;
  localparam int ENTRY_W = 4;
  localparam int DLY_W   = 32;
  localparam int KIND_W  = 3;

  localparam int SLOT_W    = $clog2(WHEEL_SLOTS);
  localparam int IDX_W     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int NREP_W    = $clog2(RESULT_LIMIT + 1);

  // largest rounds count: (2^32 - 2) / WHEEL_SLOTS
  localparam longint unsigned MAX_ROUNDS = 64'd4294967294 / WHEEL_SLOTS;
  localparam int ROUNDS_W = $clog2(MAX_ROUNDS + 1);

  localparam int S_TDATA_W = ((ENTRY_W + DLY_W + 1 + 7) / 8) * 8;
  localparam int M_TDATA_W = ((ENTRY_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_SCHEDULE = 2'd1,
    OP_CANCEL   = 2'd2
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    EV_EXPIRED   = 3'd0,
    EV_SCHEDULED = 3'd1,
    EV_REJECTED  = 3'd2,
    EV_CANCELLED = 3'd3,
    EV_IDLE      = 3'd4
  } event_kind_t;

  // one timer record; reload is kept pre-divided so a re-arm needs no divider
  typedef struct packed {
    logic [SLOT_W-1:0]   home;
    logic [ROUNDS_W-1:0] rounds;
    logic [ROUNDS_W-1:0] rl_rounds;
    logic [SLOT_W-1:0]   rl_rem;
    logic                periodic;
  } timer_rec_t;

endpackage

// ----- hdl/hashed_timer_wheel.sv -----
// Hashed timing wheel with a fixed table of timer entries.
//
// Input words (s_*): tuser carries the opcode (tick, schedule, cancel); tdata
// carries entry, delay_ticks and periodic. A word is taken when s_tvalid and
// s_tready are both high; s_tready is high only while the sequencer is idle.
// Output words (m_*): tuser is the event kind, tdata the entry index, tlast
// marks the final word caused by one input word.
// Tick: the pointer advances, then the timer table is scanned one entry per
// cycle, holding while a second expiry waits for the output register.
// Expiries come out in ascending entry order with the last one flagged.
// Schedule: delay - 1 splits into rounds (upper bits) and slot offset (low
// SLOT_W bits, WHEEL_SLOTS being a power of two); the record is written the
// next cycle, then ST_RESP loads the answer word once the output register is free.
// Rejects and cancels skip ST_WRITE and answer from ST_RESP directly.
// A result sits in the output register while the next input word is taken.
// If the receiver stalls, a reply waits, and the scan holds on a second
// expiry until the output register frees up. Reset clears the pointer and
// all armed flags; the record memory needs no clearing since only armed
// entries are read.
`include "hashed_timer_wheel_assert.svh"

module hashed_timer_wheel (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [3:0] entry, [35:4] delay_ticks, [36] periodic, [39:37] zero
  input  logic [htw_pkg::S_TDATA_W-1:0] s_tdata,
  // [1:0] opcode
  input  logic [htw_pkg::OP_W-1:0]      s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [3:0] result_entry, [7:4] zero
  output logic [htw_pkg::M_TDATA_W-1:0] m_tdata,
  // [2:0] event_kind
  output logic [htw_pkg::KIND_W-1:0]    m_tuser,
  output logic                          m_tlast
);
  import htw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RESP,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  localparam logic [SLOT_W:0] SLOTS_EXT = (SLOT_W + 1)'(WHEEL_SLOTS);

  state_t                state;
  logic [SLOT_W-1:0]     pos;
  logic [NUM_ENTRIES-1:0] armed;
  logic [IDX_W-1:0]      idx;
  logic [ENTRY_W-1:0]    cur_entry;
  logic                  cur_periodic;
  event_kind_t           resp_kind;

  // delay - 1: upper bits are the rounds, low SLOT_W bits the slot offset
  logic [DLY_W-1:0]      dly_m1;

  // expiry held back one step so the final one can carry tlast
  logic [NREP_W-1:0]     n_rep;
  logic                  pend_valid;
  logic [IDX_W-1:0]      pend_idx;

  event_kind_t           out_kind;
  logic [ENTRY_W-1:0]    out_entry;
  logic                  out_last;

  // timer record memory
  timer_rec_t            rec_mem [NUM_ENTRIES];
  timer_rec_t            rd_q;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  timer_rec_t            wr_data;

  logic [ENTRY_W-1:0]    in_entry;
  logic [DLY_W-1:0]      in_delay;
  logic                  in_periodic;
  logic [IDX_W-1:0]      in_idx;
  logic                  in_valid;

  logic                  hit;
  logic                  expire;
  logic                  report_ok;
  logic                  out_free;
  logic                  step;
  logic                  last_idx;
  logic                  push_mid;
  logic                  push_last;
  logic                  push;
  logic                  tick_take;

  // (pos + rem + 1) mod WHEEL_SLOTS, with pos and rem both below WHEEL_SLOTS
  function automatic logic [SLOT_W-1:0] add_slot(input logic [SLOT_W-1:0] p,
                                                 input logic [SLOT_W-1:0] r);
    logic [SLOT_W:0] sum;
    sum = {1'b0, p} + {1'b0, r} + (SLOT_W + 1)'(1);
    if (sum >= SLOTS_EXT) begin
      sum = sum - SLOTS_EXT;
    end
    return sum[SLOT_W-1:0];
  endfunction

  assign in_entry    = s_tdata[ENTRY_W-1:0];
  assign in_delay    = s_tdata[ENTRY_W +: DLY_W];
  assign in_periodic = s_tdata[ENTRY_W + DLY_W];
  assign in_idx      = IDX_W'(in_entry);
  assign in_valid    = (7'(in_entry) < 7'(NUM_ENTRIES));

  assign hit       = armed[idx] && (rd_q.home == pos);
  assign expire    = hit && (rd_q.rounds == '0);
  assign report_ok = (n_rep < NREP_W'(RESULT_LIMIT));
  assign out_free  = !m_tvalid || m_tready;
  assign last_idx  = (idx == IDX_W'(NUM_ENTRIES - 1));
  // a second reported expiry needs room to push the held one out
  assign step      = (state == ST_SCAN) &&
                     !(expire && report_ok && pend_valid && !out_free);

  // output register loads: held expiry mid-scan, final expiry, or a reply
  assign push_mid  = step && expire && report_ok && pend_valid;
  assign push_last = (state == ST_FLUSH) && pend_valid && out_free;
  assign push      = push_mid || push_last || ((state == ST_RESP) && out_free);
  assign tick_take = s_tvalid && s_tready && (s_tuser == OP_TICK);

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = M_TDATA_W'(out_entry);
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  // read one entry ahead while scanning
  always_comb begin
    if (state == ST_SCAN && step && !last_idx) begin
      rd_addr = idx + IDX_W'(1);
    end else if (state == ST_SCAN && !step) begin
      rd_addr = idx;
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rd_q;
    if (state == ST_WRITE) begin
      wr_en             = 1'b1;
      wr_addr           = IDX_W'(cur_entry);
      wr_data.home      = add_slot(pos, dly_m1[SLOT_W-1:0]);
      wr_data.rounds    = ROUNDS_W'(dly_m1[DLY_W-1:SLOT_W]);
      wr_data.rl_rounds = ROUNDS_W'(dly_m1[DLY_W-1:SLOT_W]);
      wr_data.rl_rem    = dly_m1[SLOT_W-1:0];
      wr_data.periodic  = cur_periodic;
    end else if (step && hit) begin
      wr_en = 1'b1;
      if (expire) begin
        wr_data.home   = add_slot(pos, rd_q.rl_rem);
        wr_data.rounds = rd_q.rl_rounds;
      end else begin
        wr_data.rounds = rd_q.rounds - ROUNDS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_mem[wr_addr] <= wr_data;
    end
    rd_q <= rec_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pos        <= '0;
      armed      <= '0;
      idx        <= '0;
      n_rep      <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            case (opcode_t'(s_tuser))
              OP_TICK: begin
                pos        <= (pos == SLOT_W'(WHEEL_SLOTS - 1)) ? '0 : pos + SLOT_W'(1);
                idx        <= '0;
                n_rep      <= '0;
                pend_valid <= 1'b0;
                state      <= ST_SCAN;
              end
              OP_SCHEDULE: begin
                cur_entry    <= in_entry;
                cur_periodic <= in_periodic;
                if (!in_valid || armed[in_idx] || in_delay == '0) begin
                  resp_kind <= EV_REJECTED;
                  state     <= ST_RESP;
                end else begin
                  dly_m1 <= in_delay - DLY_W'(1);
                  state  <= ST_WRITE;
                end
              end
              OP_CANCEL: begin
                cur_entry <= in_entry;
                if (in_valid && armed[in_idx]) begin
                  armed[in_idx] <= 1'b0;
                  resp_kind     <= EV_CANCELLED;
                end else begin
                  resp_kind <= EV_IDLE;
                end
                state <= ST_RESP;
              end
              default: ;
            endcase
          end
        end
        ST_WRITE: begin
          armed[IDX_W'(cur_entry)] <= 1'b1;
          resp_kind                <= EV_SCHEDULED;
          state                    <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            out_kind  <= resp_kind;
            out_entry <= cur_entry;
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (step) begin
            if (expire) begin
              armed[idx] <= rd_q.periodic;
              if (report_ok) begin
                if (pend_valid) begin
                  out_kind  <= EV_EXPIRED;
                  out_entry <= ENTRY_W'(pend_idx);
                  out_last  <= 1'b0;
                end
                pend_idx   <= idx;
                pend_valid <= 1'b1;
                n_rep      <= n_rep + NREP_W'(1);
              end
            end
            if (last_idx) begin
              idx   <= '0;
              state <= ST_FLUSH;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_kind   <= EV_EXPIRED;
            out_entry  <= ENTRY_W'(pend_idx);
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `HTW_ASSERT_IMP(a_pend_idle, state == ST_IDLE, !pend_valid, "held expiry left in idle")
  `HTW_ASSERT_IMP(a_rep_limit, 1'b1, n_rep <= NREP_W'(RESULT_LIMIT), "report count overrun")
  `HTW_ASSERT_NXT(a_tick_start, tick_take, state == ST_SCAN && idx == '0, "tick scan not started")
  `HTW_ASSERT_NXT(a_push_mid, push_mid, m_tvalid && !m_tlast, "held expiry not pushed")
  `HTW_ASSERT_NXT(a_flush_last, push_last, m_tvalid && m_tlast, "final expiry not flagged")

endmodule

// ----- bench/tb_hashed_timer_wheel.sv -----
// Self-checking testbench for the hashed timer wheel, checked against a predictor.
`timescale 1ns / 1ps

module tb_hashed_timer_wheel;
  import htw_pkg::*;

  // opcode value the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 240;
  // generous ceiling for the whole run, long stalls included
  localparam int CYCLE_LIMIT = 1000000;
  // drain time after the last word: room for a full tick scan
  localparam int TAIL_CYCLES = 64;

  // one command for the input stream, with the idle gap that follows it
  typedef struct {
    logic [OP_W-1:0]    op;
    logic [ENTRY_W-1:0] entry;
    logic [DLY_W-1:0]   dly;
    logic               per;
    int                 gap;
    bit                 drain;    // hold off until every due word has arrived
  } timer_cmd_t;

  // one output word as the block should emit it
  typedef struct packed {
    event_kind_t        kind;
    logic [ENTRY_W-1:0] entry;
    logic               last;
  } timer_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // [3:0] entry, [35:4] delay_ticks, [36] periodic, [39:37] zero
  logic [S_TDATA_W-1:0] s_tdata = '0;
  // [1:0] opcode
  logic [OP_W-1:0]      s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // [3:0] result_entry, [7:4] zero
  logic [M_TDATA_W-1:0] m_tdata;
  // [2:0] event_kind
  logic [KIND_W-1:0]    m_tuser;
  logic                 m_tlast;

  hashed_timer_wheel dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the wheel
  // ---------------------------------------------------------------------------
  logic [SLOT_W-1:0]   wheel_pos;
  logic                armed       [NUM_ENTRIES];
  logic [SLOT_W-1:0]   home_slot   [NUM_ENTRIES];
  logic [ROUNDS_W-1:0] rounds_left [NUM_ENTRIES];
  logic [DLY_W-1:0]    reload_period [NUM_ENTRIES];

  timer_cmd_t  cmd_q[$];     // commands not yet presented
  timer_word_t due_q[$];     // output words predicted but not yet seen
  int          errors = 0;
  int          cycles = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // place an entry on the wheel; the rounds count is such that the entry
  // fires on exactly the ticks-th tick, multiples of the slot count included
  task automatic arm_timer(input int e, input logic [DLY_W-1:0] ticks,
                           input logic reloads);
    logic [DLY_W-1:0] q;
    q = (ticks - 32'd1) / 32'(WHEEL_SLOTS);
    rounds_left[e]   = q[ROUNDS_W-1:0];
    home_slot[e]     = wheel_pos + ticks[SLOT_W-1:0];
    reload_period[e] = reloads ? ticks : '0;
    armed[e]         = 1'b1;
  endtask

  // apply one accepted command to the wheel and queue the words it causes
  task automatic wheel_predict(input timer_cmd_t c);
    timer_word_t batch [RESULT_LIMIT];
    timer_word_t w;
    int          n;
    n = 0;
    w.last = 1'b1;
    w.entry = c.entry;
    if (c.op == OP_TICK) begin
      wheel_pos = wheel_pos + SLOT_W'(1);
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (armed[i] && home_slot[i] == wheel_pos) begin
          if (rounds_left[i] == '0) begin
            armed[i] = 1'b0;
            if (n < RESULT_LIMIT) begin
              batch[n].kind  = EV_EXPIRED;
              batch[n].entry = ENTRY_W'(i);
              batch[n].last  = 1'b0;
              n++;
            end
            if (reload_period[i] != '0) arm_timer(i, reload_period[i], 1'b1);
          end else begin
            rounds_left[i] = rounds_left[i] - ROUNDS_W'(1);
          end
        end
      end
      // expiries go out in entry order, the final one flagged
      for (int k = 0; k < n; k++) begin
        w = batch[k];
        w.last = (k == n - 1);
        due_q.push_back(w);
      end
    end else if (c.op == OP_SCHEDULE) begin
      if (c.entry >= NUM_ENTRIES || armed[c.entry] || c.dly == '0) begin
        w.kind = EV_REJECTED;
      end else begin
        arm_timer(int'(c.entry), c.dly, c.per);
        w.kind = EV_SCHEDULED;
      end
      due_q.push_back(w);
    end else if (c.op == OP_CANCEL) begin
      if (c.entry < NUM_ENTRIES && armed[c.entry]) begin
        armed[c.entry] = 1'b0;
        w.kind = EV_CANCELLED;
      end else begin
        w.kind = EV_IDLE;
      end
      due_q.push_back(w);
    end
    // the unused opcode changes nothing and produces nothing
  endtask

  function automatic timer_cmd_t mk_cmd(input logic [OP_W-1:0] op,
                                        input logic [ENTRY_W-1:0] entry,
                                        input logic [DLY_W-1:0] dly,
                                        input logic per);
    timer_cmd_t c;
    c.op    = op;
    c.entry = entry;
    c.dly   = dly;
    c.per   = per;
    c.gap   = 0;
    c.drain = 1'b0;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents commands from cmd_q, predicts on each accepted word.
  // s_tvalid gets exactly one nonblocking update per edge.
  // ---------------------------------------------------------------------------
  timer_cmd_t cur_cmd;
  int         gap_left;

  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      nv = s_tvalid;
      if (s_tvalid && s_tready) begin
        wheel_predict(cur_cmd);
        gap_left = cur_cmd.gap;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() > 0 && (!cmd_q[0].drain || due_q.size() == 0)) begin
          cur_cmd = cmd_q.pop_front();
          s_tdata <= {3'b000, cur_cmd.per, cur_cmd.dly, cur_cmd.entry};
          s_tuser <= cur_cmd.op;
          nv = 1'b1;
        end
      end
      s_tvalid <= nv;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted output word against the oldest due word,
  // and throttles m_tready; in every third window of the cycle counter no new stall starts.
  // ---------------------------------------------------------------------------
  int stall_left;

  always @(posedge clk) begin
    timer_word_t want;
    int          g;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_q.size() == 0) begin
          report_mismatch("unexpected word, entry", int'(m_tdata[ENTRY_W-1:0]), -1);
        end else begin
          want = due_q.pop_front();
          if (m_tuser !== want.kind)
            report_mismatch("event_kind", int'(m_tuser), int'(want.kind));
          if (m_tdata[ENTRY_W-1:0] !== want.entry)
            report_mismatch("result_entry", int'(m_tdata[ENTRY_W-1:0]), int'(want.entry));
          if (m_tlast !== want.last)
            report_mismatch("last", int'(m_tlast), int'(want.last));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ((cycles / 1500) % 3 != 0 && $urandom_range(0, 3) == 0) begin
          g = $urandom_range(0, 9);
          stall_left = (g < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    timer_cmd_t c;
    int         n;
    int         r;
    int         d;
    int         g;

    wheel_pos = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) armed[i] = 1'b0;

    // directed part
    cmd_q.push_back(mk_cmd(OP_CANCEL,   4'd0,  32'd0, 1'b0));           // cancel of idle entry
    cmd_q.push_back(mk_cmd(OP_SCHEDULE, 4'd0,  32'd0, 1'b1));           // zero delay rejected
    cmd_q.push_back(mk_cmd(OP_SCHEDULE, 4'd0,  32'd1, 1'b0));           // shortest one-shot
    cmd_q.push_back(mk_cmd(OP_TICK,     4'd0,  32'd0, 1'b0));           // fires entry 0
    cmd_q.push_back(mk_cmd(OP_SCHEDULE, 4'd15, 32'd32, 1'b1));          // exact revolution
    cmd_q.push_back(mk_cmd(OP_SCHEDULE, 4'd15, 32'd5, 1'b0));           // entry busy, rejected
    cmd_q.push_back(mk_cmd(OP_SCHEDULE, 4'd1,  32'hFFFF_FFFF, 1'b1));   // largest delay
    cmd_q.push_back(mk_cmd(OP_SCHEDULE, 4'd2,  32'd33, 1'b0));
    cmd_q.push_back(mk_cmd(OP_SCHEDULE, 4'd3,  32'h8000_0000, 1'b0));
    cmd_q.push_back(mk_cmd(OP_SCHEDULE, 4'd4,  32'd2, 1'b1));           // short periodic
    cmd_q.push_back(mk_cmd(OP_UNUSED,   4'd9,  32'hFFFF_FFFF, 1'b1));   // ignored opcode
    for (int e = 5; e <= 12; e++)
      cmd_q.push_back(mk_cmd(OP_SCHEDULE, 4'(e), 32'd3, 1'(e & 1)));   // several in one slot
    cmd_q.push_back(mk_cmd(OP_TICK,     4'd0,  32'd0, 1'b0));
    cmd_q.push_back(mk_cmd(OP_TICK,     4'd0,  32'd0, 1'b0));           // fires entry 4
    cmd_q.push_back(mk_cmd(OP_TICK,     4'd15, 32'hFFFF_FFFF, 1'b1));
    cmd_q.push_back(mk_cmd(OP_CANCEL,   4'd1,  32'd0, 1'b0));           // cancel of armed entry
    cmd_q.push_back(mk_cmd(OP_CANCEL,   4'd3,  32'd0, 1'b1));

    // random part: about half ticks so timers actually run out, delays mostly
    // short with a share of slot multiples and full-range values
    n = 0;
    while (n < RANDOM_ITEMS) begin
      c = mk_cmd(OP_TICK, 4'($urandom_range(0, 15)), $urandom, 1'($urandom_range(0, 1)));
      r = $urandom_range(0, 99);
      if (r < 48) begin
        c.op = OP_TICK;
      end else if (r < 80) begin
        c.op = OP_SCHEDULE;
        d = $urandom_range(0, 19);
        if (d == 0)      c.dly = '0;
        else if (d == 1) c.dly = $urandom;
        else if (d == 2) c.dly = 32 * $urandom_range(1, 3);
        else if (d == 3) c.dly = $urandom_range(1, 4);
        else             c.dly = $urandom_range(1, 70);
      end else if (r < 95) begin
        c.op = OP_CANCEL;
      end else begin
        c.op = OP_UNUSED;
      end
      // stretches of 40 items with no input idling, the rest gappy
      if ((n / 40) % 2 == 1) begin
        c.gap = 0;
      end else begin
        g = $urandom_range(0, 9);
        c.gap = (g < 6) ? 0 : (g < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      c.drain = (n == RANDOM_ITEMS / 2);
      cmd_q.push_back(c);
      n++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // everything presented and taken
    while (cmd_q.size() > 0 || s_tvalid) @(posedge clk);
    // every predicted word delivered, then let stray output show up
    while (due_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && due_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
